>>> src/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int unsigned FieldW = 32;
  localparam int unsigned FuncW  = 3;
  localparam logic [FuncW-1:0] FuncAdd = 3'd0;
  localparam logic [FuncW-1:0] FuncSub = 3'd1;
  localparam logic [FuncW-1:0] FuncMul = 3'd2;
  localparam logic [FuncW-1:0] FuncDiv = 3'd3;
endpackage
`default_nettype wire

>>> src/rau_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [FieldW-1:0] first_num;
  logic [FieldW-1:0] first_den;
  logic [FieldW-1:0] second_num;
  logic [FieldW-1:0] second_den;
  modport source (output valid, func, first_num, first_den, second_num, second_den,
                  input ready);
  modport sink (input valid, func, first_num, first_den, second_num, second_den,
                output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] res_num;
  logic [FieldW-1:0] res_den;
  logic              zero_den;
  logic              overflow;
  modport source (output valid, res_num, res_den, zero_den, overflow, input ready);
  modport sink (input valid, res_num, res_den, zero_den, overflow, output ready);
endinterface
`default_nettype wire

>>> src/rau_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Shift-and-add signed multiplier, one multiplier bit per cycle.
module rau_mul #(
  parameter int unsigned W = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  output logic                done_o,
  output logic [2*W-1:0]      p_o
);
  localparam int unsigned CntW = $clog2(W + 1);
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [2*W-1:0]  acc_q, mcand_q;
  logic [W-1:0]    mplier_q;
  logic            neg_q;

  // Multiply magnitudes, fix the sign at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        acc_q    <= '0;
        mcand_q  <= {{W{1'b0}}, (a_i[W-1] ? (~a_i + 1'b1) : a_i)};
        mplier_q <= b_i[W-1] ? (~b_i + 1'b1) : b_i;
        neg_q    <= a_i[W-1] ^ b_i[W-1];
      end else if (busy_q) begin
        if (cnt_q == CntW'(W)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
          if (neg_q) acc_q <= ~acc_q + 1'b1;
        end else begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + 1'b1;
        end
      end
    end
  end
  assign p_o = acc_q;
endmodule
`default_nettype wire

>>> src/rau_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module rau_div #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] n_i,
  input  wire logic [W-1:0] d_i,
  output logic              done_o,
  output logic [W-1:0]      q_o,
  output logic [W-1:0]      r_o
);
  localparam int unsigned CntW = $clog2(W + 1);
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    q_q, r_q, d_q;
  logic [W:0]      trial;

  assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

  // Shift one dividend bit into the remainder per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        q_q    <= n_i;
        r_q    <= '0;
        d_q    <= d_i;
      end else if (busy_q) begin
        if (trial[W]) begin
          r_q <= {r_q[W-2:0], q_q[W-1]};
          q_q <= {q_q[W-2:0], 1'b0};
        end else begin
          r_q <= trial[W-1:0];
          q_q <= {q_q[W-2:0], 1'b1};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  assign q_o = q_q;
  assign r_o = r_q;
endmodule
`default_nettype wire

>>> src/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The products, the Euclid steps (up to ~1.44*WIDTH of them, typically far fewer) and
// the final divisions run on one bit-serial multiplier and one bit-serial divider,
// shared.
// Throughput: one item at a time; a new item is taken once the result transfers.
// Reset: asynchronous active low, returns to idle and drops output valid.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  localparam int unsigned W = WIDTH;
  localparam logic [3:0] StIdle = 4'd0, StM2 = 4'd2, StM3 = 4'd3,
                         StM4 = 4'd4, StSum = 4'd5, StGcd = 4'd6, StDn = 4'd7,
                         StDd = 4'd8, StFix = 4'd9, StOut = 4'd10, StMs = 4'd11;

  logic [3:0]     st_q;
  logic [FuncW-1:0] op_q;
  logic [W-1:0]   an_q, ad_q, bn_q, bd_q, n_q, d_q, p1_q, ga_q, gb_q;
  logic           ovf_q;
  logic           mstart, mdone, dstart, ddone;
  logic [W-1:0]   ma, mb, dn, dd, dq, dr;
  logic [2*W-1:0] mp;
  logic [W-1:0]   mpw;
  logic           mfit;
  logic [W:0]     sum_x;
  logic [W-1:0]   nmag, dmag;

  // Sign-extend or wrap one 32-bit field to WIDTH bits
  function automatic logic [W-1:0] ext(input logic [FieldW-1:0] f);
    logic [W+FieldW-1:0] x;
    x = {{W{f[FieldW-1]}}, f};
    return x[W-1:0];
  endfunction

  rau_mul #(.W(W)) u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
                          .done_o(mdone), .p_o(mp));
  rau_div #(.W(W)) u_div (.clk_i, .rst_ni, .start_i(dstart), .n_i(dn), .d_i(dd),
                          .done_o(ddone), .q_o(dq), .r_o(dr));

  assign mpw   = mp[W-1:0];
  assign mfit  = (mp[2*W-1:W-1] == '0) || (mp[2*W-1:W-1] == '1);
  assign nmag  = n_q[W-1] ? (~n_q + 1'b1) : n_q;
  assign dmag  = d_q[W-1] ? (~d_q + 1'b1) : d_q;
  assign sum_x = (op_q == FuncSub) ? ({p1_q[W-1], p1_q} - {n_q[W-1], n_q})
                                   : ({p1_q[W-1], p1_q} + {n_q[W-1], n_q});

  // Operand select for the shared units
  always_comb begin
    ma = an_q;
    mb = bd_q;
    case (st_q)
      StM2:    begin ma = ad_q; mb = (op_q == FuncDiv) ? bn_q : bd_q; end
      StM3:    begin ma = ad_q; mb = bn_q; end
      StMs:    begin ma = an_q; mb = (op_q == FuncMul) ? bn_q : bd_q; end
      default: begin ma = an_q; mb = bd_q; end
    endcase
    dn = ga_q;
    dd = gb_q;
    case (st_q)
      StDn:    begin dn = nmag; dd = ga_q; end
      StDd:    begin dn = dmag; dd = ga_q; end
      default: begin dn = ga_q; dd = gb_q; end
    endcase
  end

  assign in_i.ready  = (st_q == StIdle);
  assign out_o.valid = (st_q == StOut);

  logic go_q;
  assign mstart = go_q && (st_q == StMs || st_q == StM2 || st_q == StM3);
  assign dstart = go_q && (st_q == StGcd || st_q == StDn || st_q == StDd);

  // Sequence products, Euclid steps, divisions and sign fix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      go_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      case (st_q)
        StIdle: if (in_i.valid) begin
          op_q  <= in_i.func;
          an_q  <= ext(in_i.first_num);
          ad_q  <= ext(in_i.first_den);
          bn_q  <= ext(in_i.second_num);
          bd_q  <= ext(in_i.second_den);
          ovf_q <= 1'b0;
          go_q  <= 1'b1;
          if (in_i.func <= FuncDiv) st_q <= StMs;
          else begin
            n_q  <= ext(in_i.first_num);
            d_q  <= ext(in_i.first_den);
            st_q <= StM4;
          end
        end
        StMs: if (mdone) begin
          if (!mfit) ovf_q <= 1'b1;
          p1_q <= mpw;
          n_q  <= mpw;
          go_q <= 1'b1;
          st_q <= StM2;
        end
        StM2: if (mdone) begin
          if (!mfit) ovf_q <= 1'b1;
          d_q <= mpw;
          if (op_q == FuncAdd || op_q == FuncSub) begin
            go_q <= 1'b1;
            st_q <= StM3;
          end else st_q <= StM4;
        end
        StM3: if (mdone) begin
          if (!mfit) ovf_q <= 1'b1;
          n_q  <= mpw;
          st_q <= StSum;
        end
        StSum: begin
          if (sum_x[W] != sum_x[W-1]) ovf_q <= 1'b1;
          n_q  <= sum_x[W-1:0];
          st_q <= StM4;
        end
        StM4: begin
          if (d_q == '0) begin
            n_q  <= (n_q == '0) ? '0 : W'(1);
            st_q <= StOut;
          end else begin
            ga_q <= nmag;
            gb_q <= dmag;
            st_q <= StGcd;
            go_q <= (n_q != '0);
            if (n_q == '0) begin
              ga_q <= dmag;
              st_q <= StDn;
              go_q <= 1'b1;
            end
          end
        end
        StGcd: if (ddone) begin
          ga_q <= gb_q;
          gb_q <= dr;
          if (dr == '0) begin
            ga_q <= gb_q;
            st_q <= StDn;
          end
          go_q <= 1'b1;
        end
        StDn: if (ddone) begin
          n_q  <= n_q[W-1] ? (~dq + 1'b1) : dq;
          go_q <= 1'b1;
          st_q <= StDd;
        end
        StDd: if (ddone) begin
          d_q  <= d_q[W-1] ? (~dq + 1'b1) : dq;
          st_q <= StFix;
        end
        StFix: begin
          if (d_q[W-1]) begin
            n_q <= ~n_q + 1'b1;
            d_q <= ~d_q + 1'b1;
            if ((n_q != '0 && n_q == {1'b1, {(W-1){1'b0}}}) ||
                d_q == {1'b1, {(W-1){1'b0}}}) ovf_q <= 1'b1;
          end
          st_q <= StOut;
        end
        StOut: if (out_o.ready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // Present the low field bits, sign-extended when WIDTH is narrow
  logic [W+FieldW-1:0] on_x, od_x;
  assign on_x = {{FieldW{n_q[W-1]}}, n_q};
  assign od_x = {{FieldW{d_q[W-1]}}, d_q};
  assign out_o.res_num  = on_x[FieldW-1:0];
  assign out_o.res_den  = od_x[FieldW-1:0];
  assign out_o.zero_den = (d_q == '0);
  assign out_o.overflow = ovf_q;
endmodule
`default_nettype wire

>>> tb/rau_checker.sv
`timescale 1ns / 1ps
module rau_checker
  import rau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rau_in_if    in_i,
  rau_out_if   out_i,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [FieldW-1:0] num;
    logic [FieldW-1:0] den;
    logic              zero_den;
    logic              overflow;
  } fraction_t;

  fraction_t reduced_q[$];

  // Sign-extend the low 32 bits
  function automatic longint wrap_field(longint v);
    logic signed [FieldW-1:0] t;
    t = v[FieldW-1:0];
    return longint'(t);
  endfunction

  function automatic bit fits_field(longint v);
    return v >= -(64'sd1 <<< 31) && v <= ((64'sd1 <<< 31) - 1);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint wrap_mul(longint a, longint b, ref bit ovf);
    longint p;
    p = a * b;
    if (!fits_field(p)) ovf = 1'b1;
    return wrap_field(p);
  endfunction

  function automatic longint wrap_neg(longint v, ref bit ovf);
    longint r;
    r = wrap_field(-v);
    if (v != 0 && r == v) ovf = 1'b1;
    return r;
  endfunction

  function automatic longint div_mag(longint v, longint unsigned g);
    longint unsigned q;
    q = magnitude(v) / g;
    return wrap_field(v < 0 ? -longint'(q) : longint'(q));
  endfunction

  // Form the raw fraction, reduce by the gcd, make the denominator positive
  function automatic fraction_t reduce_fraction(logic [FuncW-1:0] func,
      logic [FieldW-1:0] an_f, logic [FieldW-1:0] ad_f,
      logic [FieldW-1:0] bn_f, logic [FieldW-1:0] bd_f);
    longint an, ad, bn, bd, n, d, p1, p2;
    longint unsigned x, y, t;
    bit ovf;
    fraction_t r;
    an = wrap_field(an_f); ad = wrap_field(ad_f);
    bn = wrap_field(bn_f); bd = wrap_field(bd_f);
    ovf = 1'b0;
    case (func)
      FuncAdd, FuncSub: begin
        p1 = wrap_mul(an, bd, ovf);
        p2 = wrap_mul(ad, bn, ovf);
        n = (func == FuncSub) ? p1 - p2 : p1 + p2;
        if (!fits_field(n)) ovf = 1'b1;
        n = wrap_field(n);
        d = wrap_mul(ad, bd, ovf);
      end
      FuncMul: begin
        n = wrap_mul(an, bn, ovf);
        d = wrap_mul(ad, bd, ovf);
      end
      FuncDiv: begin
        n = wrap_mul(an, bd, ovf);
        d = wrap_mul(ad, bn, ovf);
      end
      default: begin
        n = an;
        d = ad;
      end
    endcase
    if (d == 0) begin
      n = (n == 0) ? 0 : 1;
    end else begin
      x = magnitude(n);
      y = magnitude(d);
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      n = div_mag(n, x);
      d = div_mag(d, x);
      if (d < 0) begin
        n = wrap_neg(n, ovf);
        d = wrap_neg(d, ovf);
      end
    end
    r.num = n[FieldW-1:0];
    r.den = d[FieldW-1:0];
    r.zero_den = (d == 0);
    r.overflow = ovf;
    return r;
  endfunction

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want, got;
    if (!rst_ni) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_i.valid && in_i.ready)
        reduced_q.push_back(reduce_fraction(in_i.func, in_i.first_num, in_i.first_den,
                                            in_i.second_num, in_i.second_den));
      if (out_i.valid && out_i.ready) begin
        got = {out_i.res_num, out_i.res_den, out_i.zero_den, out_i.overflow};
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected result %h/%h zd=%b ov=%b", $time,
                   got.num, got.den, got.zero_den, got.overflow);
          fail_count <= fail_count + 1;
        end else begin
          want = reduced_q.pop_front();
          if (want != got) begin
            $display("%0t: expected %h/%h zd=%b ov=%b, actual %h/%h zd=%b ov=%b", $time,
                     want.num, want.den, want.zero_den, want.overflow,
                     got.num, got.den, got.zero_den, got.overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= reduced_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  localparam int unsigned RandomItems = 1330;
  localparam logic [FieldW-1:0] MinVal = 32'h8000_0000;
  localparam logic [FieldW-1:0] MaxVal = 32'h7fff_ffff;
  localparam logic [FuncW-1:0] FuncReduce = 3'd4;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   no_gaps;

  rau_in_if  in_bus ();
  rau_out_if out_bus ();

  rational_arithmetic_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  rau_checker checker_inst (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_bus),
    .out_i     (out_bus),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offer one operation, first idling for a random gap unless no_gaps is set
  task automatic send_item(logic [FuncW-1:0] func, logic [FieldW-1:0] an,
                           logic [FieldW-1:0] ad, logic [FieldW-1:0] bn,
                           logic [FieldW-1:0] bd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.first_num  <= an;
    in_bus.first_den  <= ad;
    in_bus.second_num <= bn;
    in_bus.second_den <= bd;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Mostly small operands so reductions are meaningful, some full range and zeros
  function automatic logic [FieldW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return FieldW'($signed($urandom_range(0, 200)) - 100);
    if (sel < 7) return $urandom();
    if (sel == 7) return FieldW'($signed($urandom_range(0, 131070)) - 65535);
    if (sel == 8) return $urandom_range(0, 1) ? MinVal : MaxVal;
    return '0;
  endfunction

  initial begin
    in_bus.valid = 1'b0;
    in_bus.func = '0;
    in_bus.first_num = '0;
    in_bus.first_den = '0;
    in_bus.second_num = '0;
    in_bus.second_den = '0;
    no_gaps = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every code, including the spare ones that act as reduce
    for (int f = 0; f < 8; f++) send_item(f[FuncW-1:0], 32'd6, 32'd4, 32'd3, 32'd9);
    // Zero denominator, zero over zero, zero numerator, negative denominator
    send_item(FuncReduce, 32'd7, 32'd0, '0, '0);
    send_item(FuncReduce, 32'd0, 32'd0, '0, '0);
    send_item(FuncReduce, 32'd0, -32'sd5, '0, '0);
    send_item(FuncReduce, 32'd10, -32'sd4, '0, '0);
    // Negating the most negative value
    send_item(FuncReduce, MinVal, -32'sd1, '0, '0);
    send_item(FuncReduce, 32'd1, MinVal, '0, '0);
    // Extremes and wrapping products and sums
    send_item(FuncMul, MaxVal, MaxVal, MaxVal, MaxVal);
    send_item(FuncMul, MinVal, MinVal, MinVal, MinVal);
    send_item(FuncAdd, MaxVal, 32'd1, MaxVal, 32'd1);
    send_item(FuncSub, MinVal, 32'd1, MaxVal, 32'd1);
    send_item(FuncDiv, 32'd3, 32'd5, 32'd0, 32'd7);
    send_item(FuncDiv, MinVal, MaxVal, MaxVal, MinVal);
    send_item(FuncAdd, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(FuncSub, 32'd1, 32'd3, 32'd1, 32'd3);

    for (int i = 0; i < RandomItems; i++) begin
      no_gaps = (i >= 600 && i < 700);
      send_item(FuncW'($urandom_range(0, 7)), pick_value(), pick_value(),
                pick_value(), pick_value());
    end
    in_bus.valid <= 1'b0;

    // Drain the outstanding results
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hold results off for a long stretch once, then stall at random unless no_gaps is set
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    repeat (400) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  initial begin
    #150ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
